// ===== hdl/nnsb_pkg.sv =====
// Shared types, widths and register indexes for the nearest-neighbour blit
// address generator. No dependencies.
package nnsb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_SIDE_DEF  = 4096;
  localparam int ADDR_BITS_DEF = 24;

  localparam int FRAC_W     = 29;
  localparam int IDX_W      = 13;
  localparam int SIZE_W     = 13;
  localparam int PITCH_W    = 14;
  localparam int BASE_W     = 24;
  localparam int ADDR_OUT_W = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_PITCH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 4'd7;

  typedef struct packed {
    logic [BASE_W-1:0]  src_base;
    logic [PITCH_W-1:0] src_pitch;
    logic [BASE_W-1:0]  dst_base;
    logic [PITCH_W-1:0] dst_pitch;
    logic [SIZE_W-1:0]  src_width;
    logic [SIZE_W-1:0]  src_height;
    logic [SIZE_W-1:0]  dst_width;
    logic [SIZE_W-1:0]  dst_height;
  } nnsb_cfg_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic restart;
  } nnsb_q_t;

endpackage

// ===== hdl/nnsb_front.sv =====
// Front end: takes requests and holds them in a short queue for the back end.
// Depends on nnsb_pkg.
module nnsb_front import nnsb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    restart,
  output nnsb_q_t q,
  input  logic    q_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [QDEPTH-1:0] entry;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_stall  = (count == CNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign pop       = q_pop && (count != '0);
  assign q.valid   = (count != '0);
  assign q.restart = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= restart;
    end
  end

endmodule

// ===== hdl/nnsb_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nnsb_pkg only through the import convention.
module nnsb_div import nnsb_pkg::*; #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out of quo while quotient bits enter from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/nnsb_back.sv =====
// Back end: raster walk state, step division, address arithmetic and the
// output register. Depends on nnsb_pkg and nnsb_div.
module nnsb_back import nnsb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nnsb_cfg_t             cfg,
  input  nnsb_q_t               q,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_OUT_W-1:0] src_addr,
  output logic [ADDR_OUT_W-1:0] dst_addr,
  output logic                  row_end,
  output logic                  blit_end
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int NUM_W   = SIDE_W + FRAC_BITS;
  localparam int INT_W   = FRAC_W - FRAC_BITS;
  localparam int CMP_W   = SIZE_W + 1;
  localparam int SPROD_W = INT_W + PITCH_W;
  localparam int DPROD_W = IDX_W + PITCH_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (vx > CMP_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return SIDE_W'(v);
    end
  endfunction

  state_t             state;
  logic [IDX_W-1:0]   col;
  logic [IDX_W-1:0]   row;
  logic [FRAC_W-1:0]  frac_col;
  logic [FRAC_W-1:0]  frac_row;
  logic [FRAC_W-1:0]  step_col;
  logic [FRAC_W-1:0]  step_row;
  logic [ADDR_BITS-1:0] prod_src;
  logic [ADDR_BITS-1:0] prod_dst;

  logic [SIDE_W-1:0]  sw, sh, dw, dh;
  logic               first;
  logic               div_start;
  logic               div_done;
  logic               div_done_row;
  logic [NUM_W-1:0]   quo_col;
  logic [NUM_W-1:0]   quo_row;
  logic [SPROD_W-1:0] mul_src;
  logic [DPROD_W-1:0] mul_dst;
  logic [ADDR_BITS-1:0] sum_src;
  logic [ADDR_BITS-1:0] sum_dst;
  logic               re_now;
  logic               be_now;
  logic               out_free;

  assign sw = clamp_side(cfg.src_width);
  assign sh = clamp_side(cfg.src_height);
  assign dw = clamp_side(cfg.dst_width);
  assign dh = clamp_side(cfg.dst_height);

  assign first     = q.restart || ((col == '0) && (row == '0));
  assign q_pop     = (state == ST_IDLE) && q.valid;
  assign div_start = q_pop && first;

  nnsb_div #(.NUM_W(NUM_W), .DEN_W(SIDE_W)) u_div_col (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({sw, {FRAC_BITS{1'b0}}}),
    .den   (dw),
    .done  (div_done),
    .quo   (quo_col)
  );

  nnsb_div #(.NUM_W(NUM_W), .DEN_W(SIDE_W)) u_div_row (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({sh, {FRAC_BITS{1'b0}}}),
    .den   (dh),
    .done  (div_done_row),
    .quo   (quo_row)
  );

  assign mul_src = SPROD_W'(frac_row[FRAC_W-1:FRAC_BITS]) * SPROD_W'(cfg.src_pitch);
  assign mul_dst = DPROD_W'(row) * DPROD_W'(cfg.dst_pitch);

  assign sum_src = ADDR_BITS'(cfg.src_base) + prod_src
                 + ADDR_BITS'(frac_col[FRAC_W-1:FRAC_BITS]);
  assign sum_dst = ADDR_BITS'(cfg.dst_base) + prod_dst + ADDR_BITS'(col);

  // row and pass ends compare against the live sizes
  assign re_now   = CMP_W'(col) >= (CMP_W'(dw) - CMP_W'(1));
  assign be_now   = re_now && (CMP_W'(row) >= (CMP_W'(dh) - CMP_W'(1)));
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      frac_col  <= '0;
      frac_row  <= '0;
      step_col  <= '0;
      step_row  <= '0;
    end else begin
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q.valid) begin
            if (first) begin
              col      <= '0;
              row      <= '0;
              frac_col <= '0;
              frac_row <= '0;
              state    <= ST_DIV;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          if (div_done && div_done_row) begin
            step_col <= FRAC_W'(quo_col);
            step_row <= FRAC_W'(quo_row);
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
            if (be_now) begin
              col      <= '0;
              row      <= '0;
              frac_col <= '0;
              frac_row <= '0;
            end else if (re_now) begin
              col      <= '0;
              frac_col <= '0;
              row      <= row + IDX_W'(1);
              frac_row <= frac_row + step_row;
            end else begin
              col      <= col + IDX_W'(1);
              frac_col <= frac_col + step_col;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod_src <= ADDR_BITS'(mul_src);
      prod_dst <= ADDR_BITS'(mul_dst);
    end
    if ((state == ST_EMIT) && out_free) begin
      src_addr <= ADDR_OUT_W'(sum_src);
      dst_addr <= ADDR_OUT_W'(sum_dst);
      row_end  <= re_now;
      blit_end <= be_now;
    end
  end

endmodule

// ===== hdl/nearest_neighbor_scale_blit_addr_top.sv =====
// Top level of the nearest-neighbour blit address generator: configuration
// registers, front queue and back end. Depends on nnsb_pkg, nnsb_front, nnsb_back.
//
//   channel   valid      stall      payload
//   request   in_valid   in_stall   restart
//   result    out_valid  out_stall  src_addr, dst_addr, row_end, blit_end
//   config    cfg_write  -          cfg_index, cfg_data
//
// In a steady run each request passes queue pop, product register and sum into the
// output register. The first pixel of a pass also waits for the dividers, which
// produce one quotient bit a cycle.
// Reset clears the queue, walk indices and output valid and restores register defaults.
// in_stall rises while the two-entry request queue is full; out_stall holds the
// result register and the back end waits in its sum step.
module nearest_neighbor_scale_blit_addr_top import nnsb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_OUT_W-1:0] src_addr,
  output logic [ADDR_OUT_W-1:0] dst_addr,
  output logic                  row_end,
  output logic                  blit_end
);

  nnsb_cfg_t cfg;
  nnsb_q_t   q;
  logic      q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_base   <= '0;
      cfg.src_pitch  <= PITCH_W'(320);
      cfg.dst_base   <= '0;
      cfg.dst_pitch  <= PITCH_W'(320);
      cfg.src_width  <= SIZE_W'(320);
      cfg.src_height <= SIZE_W'(200);
      cfg.dst_width  <= SIZE_W'(320);
      cfg.dst_height <= SIZE_W'(200);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SRC_BASE:   cfg.src_base   <= cfg_data[BASE_W-1:0];
        REG_SRC_PITCH:  cfg.src_pitch  <= cfg_data[PITCH_W-1:0];
        REG_DST_BASE:   cfg.dst_base   <= cfg_data[BASE_W-1:0];
        REG_DST_PITCH:  cfg.dst_pitch  <= cfg_data[PITCH_W-1:0];
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: cfg.src_height <= cfg_data[SIZE_W-1:0];
        REG_DST_WIDTH:  cfg.dst_width  <= cfg_data[SIZE_W-1:0];
        REG_DST_HEIGHT: cfg.dst_height <= cfg_data[SIZE_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  nnsb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (restart),
    .q        (q),
    .q_pop    (q_pop)
  );

  nnsb_back #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_SIDE  (MAX_SIDE),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q         (q),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .row_end   (row_end),
    .blit_end  (blit_end)
  );

endmodule

// ===== hdl/nnsb_checker.sv =====
// Port-level checks for the blit address generator, bound to the top level.
// Depends on nnsb_pkg.
module nnsb_checker import nnsb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ADDR_OUT_W-1:0] src_addr,
  input logic [ADDR_OUT_W-1:0] dst_addr,
  input logic                  row_end,
  input logic                  blit_end
);

  logic [2:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // requests taken whose result has not yet been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_take && !out_take) begin
      pending <= pending + 3'd1;
    end else if (out_take && !in_take) begin
      pending <= pending - 3'd1;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(src_addr) && $stable(dst_addr)
                               && $stable(row_end) && $stable(blit_end))
    else $error("result dropped or changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending request");

  a_full_queue: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> pending >= 3'd2)
    else $error("input stalled with the queue not full");

  a_end_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && blit_end |-> row_end)
    else $error("pass end without row end");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind nearest_neighbor_scale_blit_addr_top nnsb_checker u_checker (.*);
